// ===== sv/olar_pkg.sv =====
// ----------------------------------------------------------------------------
// olar_pkg
// shared codes and types for the ordered list append/remove block
// ----------------------------------------------------------------------------
package olar_pkg;

    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SHOW   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd5;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } state_t;

    // per-cell control decoded by the top level
    typedef struct packed {
        logic valid;      // cell holds a live entry
        logic write_here; // append lands in this cell
        logic is_tail;    // last live cell
        logic remove_en;  // remove request in progress
        logic rotate_en;  // show rotation step
    } cell_ctrl_t;

endpackage

// ===== sv/olar_cell.sv =====
// ----------------------------------------------------------------------------
// olar_cell
// one list entry: compare, append write, shift-up on remove, show rotation
// ----------------------------------------------------------------------------
module olar_cell (
    input  logic                aclk,
    input  olar_pkg::cell_ctrl_t ctrl,
    input  olar_pkg::data_t     req_value,
    input  olar_pkg::data_t     next_value,
    input  olar_pkg::data_t     head_value,
    input  logic                match_in,
    output olar_pkg::data_t     data_out,
    output logic                match_out
);

    olar_pkg::data_t data_reg;
    olar_pkg::data_t data_next;
    logic            match_here;

    assign match_here = ctrl.valid && (data_reg == req_value);
    assign match_out  = match_in || match_here;
    assign data_out   = data_reg;

    always_comb begin
        data_next = data_reg;
        if (ctrl.write_here) begin
            data_next = req_value;
        end else if (ctrl.remove_en && match_out) begin
            data_next = next_value;
        end else if (ctrl.rotate_en && ctrl.valid) begin
            data_next = ctrl.is_tail ? head_value : next_value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ===== sv/ordered_list_append_remove.sv =====
// ----------------------------------------------------------------------------
// ordered_list_append_remove
// ordered list of signed 32-bit values held in a row of cells, with append,
// remove-first-match and show requests
// ----------------------------------------------------------------------------
//  channel | tdata          | tuser            | tlast
//  s_      | [31:0] value   | [1:0] req_type   | -
//  m_      | [31:0] entry   | [2:0] status     | last result of a request
//
//  append and remove: all cells compare in parallel and shift up behind the first
//  match in the same edge
//  show: after the request cycle, one beat a cycle while the m_ side is free, as the
//  live cells rotate toward the head; an empty show gives a single empty result; no
//  request is taken during a show
//  a single output register holds the result; a stalled m_ side stalls s_
//  synchronous active-low reset clears count and control; entries need none
// ----------------------------------------------------------------------------
module ordered_list_append_remove #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] value
    input  logic [1:0]  s_tuser,  // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] entry_value
    output logic [2:0]  m_tuser,  // [2:0] status
    output logic        m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    olar_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    remain_reg, remain_next;

    logic                             m_valid_reg, m_valid_next;
    logic [olar_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;
    olar_pkg::data_t                  m_data_reg, m_data_next;
    logic                             m_last_reg, m_last_next;

    logic            out_free;
    logic            in_accept;
    logic [1:0]      req;
    olar_pkg::data_t req_value;
    logic            do_append;
    logic            do_remove;
    logic            do_rotate;
    logic            found;

    olar_pkg::cell_ctrl_t ctrl   [CAPACITY];
    olar_pkg::data_t      cell_q [CAPACITY];
    olar_pkg::data_t      nxt_q  [CAPACITY];
    logic [CAPACITY:0]    match_c;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == olar_pkg::S_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;
    assign req       = s_tuser;
    assign req_value = s_tdata;

    assign do_append = in_accept && (req == olar_pkg::REQ_APPEND)
                       && (count_reg != CW'(CAPACITY));
    assign do_remove = in_accept && (req == olar_pkg::REQ_REMOVE);
    assign do_rotate = (state_reg == olar_pkg::S_SHOW) && out_free;

    assign match_c[0] = 1'b0;
    assign found      = match_c[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == CAPACITY - 1) begin : g_end
            assign nxt_q[i] = '0;
        end else begin : g_mid
            assign nxt_q[i] = cell_q[i+1];
        end

        always_comb begin
            ctrl[i].valid      = count_reg > CW'(i);
            ctrl[i].write_here = do_append && (count_reg == CW'(i));
            ctrl[i].is_tail    = count_reg == CW'(i + 1);
            ctrl[i].remove_en  = do_remove;
            ctrl[i].rotate_en  = do_rotate;
        end

        olar_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl[i]),
            .req_value  (req_value),
            .next_value (nxt_q[i]),
            .head_value (cell_q[0]),
            .match_in   (match_c[i]),
            .data_out   (cell_q[i]),
            .match_out  (match_c[i+1])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            olar_pkg::S_IDLE: begin
                if (in_accept) begin
                    m_data_next = '0;
                    m_last_next = 1'b1;
                    case (req)
                        olar_pkg::REQ_APPEND: begin
                            m_valid_next = 1'b1;
                            if (count_reg == CW'(CAPACITY)) begin
                                m_status_next = olar_pkg::ST_FULL;
                            end else begin
                                m_status_next = olar_pkg::ST_APPENDED;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        olar_pkg::REQ_REMOVE: begin
                            m_valid_next = 1'b1;
                            if (count_reg == '0) begin
                                m_status_next = olar_pkg::ST_EMPTY;
                            end else if (found) begin
                                m_status_next = olar_pkg::ST_REMOVED;
                                count_next    = count_reg - 1'b1;
                            end else begin
                                m_status_next = olar_pkg::ST_NOT_FOUND;
                            end
                        end
                        olar_pkg::REQ_SHOW: begin
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = olar_pkg::ST_EMPTY;
                            end else begin
                                state_next  = olar_pkg::S_SHOW;
                                remain_next = count_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            olar_pkg::S_SHOW: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = olar_pkg::ST_ENTRY;
                    m_data_next   = cell_q[0];
                    m_last_next   = remain_reg == CW'(1);
                    remain_next   = remain_reg - 1'b1;
                    if (remain_reg == CW'(1)) begin
                        state_next = olar_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = olar_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= olar_pkg::S_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
